[rtl/sidr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidr_pkg: shared types and codes for the sample insert/drop resampler
// Opcodes, status codes, sizes and the queue word passed from front to back.
// ----------------------------------------------------------------------------
package sidr_pkg;

    localparam int MAX_BLOCK     = 8192;
    localparam int BLOCK_GRANULE = 1024;
    localparam int TABLE_DEPTH   = 1024;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;
    localparam logic [1:0] OP_START = 2'd3;

    localparam logic [2:0] ST_COPY   = 3'd0;
    localparam logic [2:0] ST_INSERT = 3'd1;
    localparam logic [2:0] ST_PAD    = 3'd2;
    localparam logic [2:0] ST_NEED   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [15:0]        entry_index;
        logic signed [32:0] entry_value;
        logic signed [31:0] sample_in;
    } t_cmd;

endpackage
`default_nettype wire

[rtl/sidr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidr_in_if / sidr_out_if: valid/ready channels of the resampler
// One input word carries a command; one output word carries a result.
// ----------------------------------------------------------------------------
interface sidr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [9:0]         entry_index;
    logic signed [32:0] entry_value;
    logic signed [31:0] sample_in;
    modport source (output valid, opcode, entry_index, entry_value, sample_in,
                    input ready);
    modport sink (input valid, opcode, entry_index, entry_value, sample_in,
                  output ready);
endinterface

interface sidr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_out;
    logic [2:0]         status;
    modport source (output valid, sample_out, status, input ready);
    modport sink (input valid, sample_out, status, output ready);
endinterface
`default_nettype wire

[rtl/sidr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidr_front: input stage and command queue
// Accept words and hold them in a short queue for the back end.
// ----------------------------------------------------------------------------
module sidr_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    sidr_in_if.sink               i_in,
    output logic                  o_cmd_valid,
    output sidr_pkg::t_cmd        o_cmd,
    input  wire                   i_cmd_pop
);
    import sidr_pkg::*;

    t_cmd       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push;

    assign i_in.ready  = (r_cnt != 3'd4);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 3'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].opcode      <= i_in.opcode;
            r_q[r_wp].entry_index <= {6'd0, i_in.entry_index};
            r_q[r_wp].entry_value <= i_in.entry_value;
            r_q[r_wp].sample_in   <= i_in.sample_in;
        end
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (i_cmd_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, i_cmd_pop};
        end
    end

    a_nopop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd4) |-> !push) else $error("push into full queue");
endmodule
`default_nettype wire

[rtl/sidr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidr_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncate toward zero.
// ----------------------------------------------------------------------------
module sidr_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire signed [45:0] i_num,
    input  wire        [16:0] i_den,
    output logic              o_busy,
    output logic signed [31:0] o_quo
);
    logic [45:0] r_n, r_q;
    logic [46:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [46:0] trial;

    assign trial = {r_rem[45:0], r_n[45]} - {30'd0, i_den};
    assign o_quo = r_neg ? 32'(-r_q) : 32'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy <= 1'b0; r_cnt <= '0;
        end else if (i_start) begin
            o_busy <= 1'b1;
            r_cnt  <= 6'd46;
            r_neg  <= i_num[45];
            r_n    <= i_num[45] ? 46'(-i_num) : i_num;
            r_rem  <= '0;
            r_q    <= '0;
        end else if (o_busy) begin
            if (!trial[46]) begin
                r_rem <= trial;
                r_q   <= {r_q[44:0], 1'b1};
            end else begin
                r_rem <= {r_rem[45:0], r_n[45]};
                r_q   <= {r_q[44:0], 1'b0};
            end
            r_n   <= {r_n[44:0], 1'b0};
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) o_busy <= 1'b0;
        end
    end
endmodule
`default_nettype wire

[rtl/sidr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidr_back: command execution
// Own the block store, position table and run counters; emit drain results.
// ----------------------------------------------------------------------------
module sidr_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire         [31:0] i_cfg_wdata,
    input  wire                i_cmd_valid,
    input  sidr_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    sidr_out_if.source         o_out
);
    import sidr_pkg::*;

    localparam int BW = $clog2(MAX_BLOCK);
    localparam int TW = $clog2(TABLE_DEPTH);
    localparam int LW = BW + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_DRAIN = 6'b000010, S_TRD = 6'b000100,
        S_EVAL = 6'b001000, S_DIV = 6'b010000, S_OUT = 6'b100000
    } t_state;

    logic signed [31:0] r_store [MAX_BLOCK];
    logic signed [32:0] r_table [TABLE_DEPTH];
    logic signed [31:0] r_sdat;
    logic signed [32:0] r_tdat;

    t_state             r_st;
    logic [31:0]        r_total;
    logic signed [45:0] r_sum;
    logic signed [31:0] r_avg;
    logic [LW-1:0]      r_len, r_fill, r_rpos;
    logic [31:0]        r_taken, r_outs;
    logic [32:0]        r_cons;
    logic [TW-1:0]      r_tp;
    logic               r_ov;
    logic signed [31:0] r_osmp;
    logic [2:0]         r_ost;
    logic               r_div_go;

    logic [LW-1:0] avail;
    logic [31:0]   work, rest;
    logic [32:0]   mag;
    logic          div_busy;
    logic signed [31:0] div_q;
    logic          take;

    always_comb begin
        work = (r_total < 32'(MAX_BLOCK)) ? r_total : 32'(MAX_BLOCK);
        work = (work / BLOCK_GRANULE) * BLOCK_GRANULE;
        rest = r_total - r_taken;
        if (r_taken >= r_total) avail = '0;
        else avail = LW'((rest < work) ? rest : work);
    end

    assign mag = r_tdat[32] ? 33'(-r_tdat) : 33'(r_tdat);
    assign o_out.valid      = r_ov;
    assign o_out.sample_out = r_osmp;
    assign o_out.status     = r_ost;

    // pop the queue head once its command is taken in the idle state
    assign take      = (r_st == S_IDLE) && i_cmd_valid && !r_ov;
    assign o_cmd_pop = take;

    sidr_div u_div (.i_clk, .i_rst_n, .i_start(r_div_go), .i_num(r_sum),
                    .i_den({{(17-LW){1'b0}}, r_len}), .o_busy(div_busy), .o_quo(div_q));

    // store and table ports, registered reads
    always_ff @(posedge i_clk) begin
        r_sdat <= r_store[r_rpos[BW-1:0]];
        r_tdat <= r_table[r_tp];
        if (take && i_cmd.opcode == OP_PUSH &&
            r_fill < ((r_fill == '0) ? avail : r_len))
            r_store[r_fill[BW-1:0]] <= i_cmd.sample_in;
        if (take && i_cmd.opcode == OP_LOAD &&
            i_cmd.entry_index < 16'(TABLE_DEPTH))
            r_table[i_cmd.entry_index[TW-1:0]] <= i_cmd.entry_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_total <= '0; r_sum <= '0; r_avg <= '0;
            r_len <= '0; r_fill <= '0; r_rpos <= '0; r_taken <= '0;
            r_outs <= '0; r_cons <= '0; r_tp <= '0; r_ov <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (i_cfg_we) r_total <= i_cfg_wdata;
            if (r_ov && o_out.ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid && !r_ov) begin
                        unique case (i_cmd.opcode)
                            OP_PUSH: begin
                                if (r_fill == '0) r_len <= avail;
                                if (r_fill < ((r_fill == '0) ? avail : r_len)) begin
                                    r_sum   <= r_sum + 46'(i_cmd.sample_in);
                                    r_fill  <= r_fill + LW'(1);
                                    r_taken <= r_taken + 32'd1;
                                    if (r_fill + LW'(1) == ((r_fill == '0) ? avail : r_len)) begin
                                        r_div_go <= 1'b1;
                                        r_st <= S_DIV;
                                    end
                                end
                            end
                            OP_DRAIN: begin
                                if (r_outs >= r_total) begin
                                    r_ov <= 1'b1; r_osmp <= '0; r_ost <= ST_DONE;
                                end else begin
                                    if (r_fill == '0) r_len <= avail;
                                    r_st <= S_DRAIN;
                                end
                            end
                            OP_START: begin
                                r_sum <= '0; r_avg <= '0; r_len <= '0; r_fill <= '0;
                                r_rpos <= '0; r_taken <= '0; r_cons <= '0;
                                r_outs <= '0; r_tp <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: if (!r_div_go && !div_busy) begin
                    r_avg <= div_q; r_st <= S_IDLE;
                end
                S_DRAIN: begin
                    if (r_len == '0) begin
                        r_ov <= 1'b1; r_osmp <= '0; r_ost <= ST_PAD; r_st <= S_IDLE;
                    end else if (r_fill < r_len) begin
                        r_ov <= 1'b1; r_osmp <= '0; r_ost <= ST_NEED; r_st <= S_IDLE;
                    end else if (r_rpos >= r_len) begin
                        // retire the block and reload its length
                        r_fill <= '0; r_rpos <= '0; r_sum <= '0; r_len <= avail;
                    end else r_st <= S_TRD;
                end
                S_TRD: r_st <= S_EVAL;
                S_EVAL: begin
                    if (r_cons >= mag) begin
                        r_tp <= (r_tp == TW'(TABLE_DEPTH - 1)) ? '0 : r_tp + TW'(1);
                        if (!r_tdat[32] && r_tdat != '0) begin
                            r_outs <= r_outs + 32'd1;
                            r_ov <= 1'b1; r_osmp <= r_avg; r_ost <= ST_INSERT;
                            r_st <= S_IDLE;
                        end else begin
                            r_cons <= r_cons + 33'd1; r_rpos <= r_rpos + LW'(1);
                            r_st <= S_DRAIN;
                        end
                    end else begin
                        r_rpos <= r_rpos + LW'(1); r_cons <= r_cons + 33'd1;
                        r_outs <= r_outs + 32'd1;
                        r_ov <= 1'b1; r_osmp <= r_sdat; r_ost <= ST_COPY;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> $stable(r_osmp) && $stable(r_ost))
        else $error("result changed while stalled");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rpos <= r_fill || r_fill == '0) else $error("read past fill");
    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ost >= ST_PAD) |-> r_osmp == '0) else $error("nonzero pad");
endmodule
`default_nettype wire

[rtl/sample_insert_drop_resampler_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sample_insert_drop_resampler_core: insert/drop resampler top level
// Load, push and start words execute in the idle state; a drain answers from idle
// once the run is finished, from S_DRAIN on pad or need-more, from S_EVAL (via
// S_TRD) on copy or insert; each chained drop or retired block repeats S_DRAIN.
// The push that fills a block holds the back end in S_DIV for the divider.
// Up to four words queue ahead; a held result blocks the back end until taken.
// Synchronous active-low reset clears queue, state, counters, total_samples only.
// ----------------------------------------------------------------------------
module sample_insert_drop_resampler_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_wdata,
    sidr_in_if.sink     i_in,
    sidr_out_if.source  o_out
);
    import sidr_pkg::*;

    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    // front: accept and queue words
    sidr_front u_front (.i_clk, .i_rst_n, .i_in, .o_cmd_valid(cmd_valid),
                        .o_cmd(cmd), .i_cmd_pop(cmd_pop));

    // back: execute commands, pop the head word when it is taken
    sidr_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_cmd_valid(cmd_valid),
        .i_cmd(cmd), .o_cmd_pop(cmd_pop), .o_out);
endmodule
`default_nettype wire

[tb/sv/sample_insert_drop_resampler_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_insert_drop_resampler_core_test: self-checking bench for the resampler
// Builds command streams (table loads, sample pushes, drains, run starts),
// predicts each drain result with a behavioral model of the block, and checks
// every output word in order under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module sample_insert_drop_resampler_core_test;
    import sidr_pkg::*;

    typedef struct {
        logic [1:0]         opcode;
        logic [9:0]         entry_index;
        logic signed [32:0] entry_value;
        logic signed [31:0] sample_in;
    } cmd_t;

    typedef struct {
        logic signed [31:0] sample;
        logic [2:0]         status;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    sidr_in_if  in_ch ();
    sidr_out_if out_ch ();

    sample_insert_drop_resampler_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioral model of the resampler state
    // ------------------------------------------------------------------
    logic signed [31:0] mdl_store [8192];
    longint             mdl_table [1024];
    longint             mdl_sum;
    logic signed [31:0] mdl_avg;
    longint             mdl_len, mdl_fill, mdl_rd;
    longint             mdl_taken, mdl_consumed, mdl_written;
    int                 mdl_ptr;
    longint             mdl_total;

    function automatic void clear_run();
        mdl_sum = 0; mdl_avg = '0; mdl_len = 0; mdl_fill = 0; mdl_rd = 0;
        mdl_taken = 0; mdl_consumed = 0; mdl_written = 0; mdl_ptr = 0;
    endfunction

    function automatic longint block_room();
        longint work;
        longint rest;
        work = (mdl_total < 8192) ? mdl_total : 8192;
        work = (work / 1024) * 1024;
        if (mdl_taken >= mdl_total) return 0;
        rest = mdl_total - mdl_taken;
        return (rest < work) ? rest : work;
    endfunction

    function automatic void take_sample(logic signed [31:0] s);
        if (mdl_fill == 0) mdl_len = block_room();
        if (mdl_fill >= mdl_len || mdl_fill >= 8192) return;
        mdl_store[mdl_fill] = s;
        mdl_sum += longint'(s);
        mdl_fill++;
        mdl_taken++;
        if (mdl_fill == mdl_len) mdl_avg = 32'(mdl_sum / mdl_len);
    endfunction

    function automatic result_t drain_one();
        result_t r;
        longint  e;
        longint  mag;
        r.sample = '0;
        if (mdl_written >= mdl_total) begin
            r.status = ST_DONE;
            return r;
        end
        if (mdl_fill == 0) mdl_len = block_room();
        forever begin
            if (mdl_len == 0) begin
                r.status = ST_PAD;
                return r;
            end
            if (mdl_fill < mdl_len) begin
                r.status = ST_NEED;
                return r;
            end
            if (mdl_rd >= mdl_len) begin
                // block used up: recycle it and size the next one
                mdl_fill = 0; mdl_rd = 0; mdl_sum = 0;
                mdl_len = block_room();
                continue;
            end
            e = mdl_table[mdl_ptr];
            mag = (e < 0) ? -e : e;
            if (mdl_consumed >= mag) begin
                mdl_ptr = (mdl_ptr == 1023) ? 0 : mdl_ptr + 1;
                if (e > 0) begin
                    mdl_written++;
                    r.sample = mdl_avg;
                    r.status = ST_INSERT;
                    return r;
                end
                // drop: skip the sample, no output
                mdl_consumed++;
                mdl_rd++;
                continue;
            end
            r.sample = mdl_store[mdl_rd];
            r.status = ST_COPY;
            mdl_rd++;
            mdl_consumed++;
            mdl_written++;
            return r;
        end
    endfunction

    // ------------------------------------------------------------------
    // Command queue, expected results, counters
    // ------------------------------------------------------------------
    cmd_t    cmd_queue [$];
    result_t expected_results [$];
    int      cmds_queued = 0;
    int      cmds_accepted = 0;
    int      errors = 0;

    // Advance the model by one word and queue it for the driver.
    task automatic enqueue(cmd_t c);
        case (c.opcode)
            OP_LOAD:  mdl_table[c.entry_index] = longint'(c.entry_value);
            OP_PUSH:  take_sample(c.sample_in);
            OP_DRAIN: expected_results.push_back(drain_one());
            default:  clear_run();
        endcase
        cmd_queue.push_back(c);
        cmds_queued++;
    endtask

    function automatic cmd_t noise_cmd(logic [1:0] op);
        cmd_t c;
        c.opcode = op;
        c.entry_index = 10'($urandom);
        c.entry_value = {1'($urandom), 32'($urandom)};
        c.sample_in = 32'($urandom);
        return c;
    endfunction

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'($signed($urandom_range(15)) - 8);
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic send(logic [1:0] op);
        cmd_t c;
        c = noise_cmd(op);
        if (op == OP_PUSH) c.sample_in = pick_sample();
        enqueue(c);
    endtask

    task automatic send_load(int idx, logic signed [32:0] val);
        cmd_t c;
        c = noise_cmd(OP_LOAD);
        c.entry_index = 10'(idx);
        c.entry_value = val;
        enqueue(c);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued words, hold until accepted
    // ------------------------------------------------------------------
    int in_gap = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.opcode      <= '0;
            in_ch.entry_index <= '0;
            in_ch.entry_value <= '0;
            in_ch.sample_in   <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) cmds_accepted++;
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    cmd_t c;
                    c = cmd_queue.pop_front();
                    in_ch.opcode      <= c.opcode;
                    in_ch.entry_index <= c.entry_index;
                    in_ch.entry_value <= c.entry_value;
                    in_ch.sample_in   <= c.sample_in;
                    in_ch.valid       <= 1'b1;
                    in_gap = pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, compare each word with the oldest
    // expected result
    // ------------------------------------------------------------------
    int out_stall = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word, status", out_ch.status, -1);
                end else begin
                    result_t w;
                    w = expected_results.pop_front();
                    if (out_ch.status !== w.status)
                        report_mismatch("status", out_ch.status, w.status);
                    if (out_ch.sample_out !== w.sample)
                        report_mismatch("sample_out", out_ch.sample_out, w.sample);
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(99) < 15) out_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------
    // Wait until every word is taken and answered, then let the divider and
    // back end go quiet.
    task automatic wait_idle();
        while (cmds_accepted != cmds_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_total(logic [31:0] v);
        wait_idle();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mdl_total = longint'(v);
    endtask

    // One run with a progressive position table and random content.
    task automatic random_run(logic [31:0] total);
        longint pos;
        longint mag;
        longint steps;
        int     k;
        int     r;
        write_total(total);
        pos = 0;
        for (k = 0; k < 64; k++) begin
            pos += $urandom_range(12);
            mag = ($urandom_range(9) == 0) ? $urandom_range(pos) : pos;
            r = $urandom_range(99);
            if (r < 25)      send_load(k, 33'(-mag));
            else if (r < 35) send_load(k, 33'sd0);
            else             send_load(k, 33'(mag));
        end
        // park the pointer on an entry that is never reached
        send_load(64, 33'sh0_FFFF_FFFF);
        send(OP_START);
        steps = 0;
        while (mdl_written < mdl_total && steps < 1150) begin
            bit want_push;
            want_push = (mdl_fill == 0) ? (block_room() > 0) : (mdl_fill < mdl_len);
            r = $urandom_range(999);
            if (r < 30)      send_load($urandom_range(1023, 900), {1'($urandom), 32'($urandom)});
            else if (r < 80) send(want_push ? OP_DRAIN : OP_PUSH);
            else             send(want_push ? OP_PUSH : OP_DRAIN);
            steps++;
        end
        repeat (3) send(OP_DRAIN);
    endtask

    initial begin
        mdl_total = 0;
        clear_run();
        cfg_we = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // total of zero after reset: run finished, push ignored
        send(OP_DRAIN);
        send(OP_PUSH);
        send(OP_START);
        send_load(0, 33'sh1_0000_0000);
        send_load(1023, 33'sh0_FFFF_FFFF);
        send_load(0, {1'($urandom), 32'($urandom)});
        send_load(1023, {1'($urandom), 32'($urandom)});
        send(OP_DRAIN);

        // run shorter than one granule: pad only
        write_total(32'd7);
        send(OP_START);
        repeat (2) send(OP_PUSH);
        repeat (9) send(OP_DRAIN);

        // largest run: block never fills, drains ask for more input
        write_total(32'hFFFF_FFFF);
        send(OP_START);
        repeat (16) send(OP_PUSH);
        repeat (3) send(OP_DRAIN);
        send(OP_START);

        // one full block, then a short tail block
        random_run(32'($urandom_range(1100, 1025)));

        write_total(32'd0);
        send(OP_DRAIN);
        wait_idle();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
